/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the sorted list engine
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge while out of reset
`define SLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/sle_pkg.sv */
// ----------------------------------------------------------------------------
// sle_pkg
// types, codes and sizes shared by the sorted list engine
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam logic [2:0] MODE_INSERT     = 3'd0;
  localparam logic [2:0] MODE_POP_MIN    = 3'd1;
  localparam logic [2:0] MODE_POP_MAX    = 3'd2;
  localparam logic [2:0] MODE_REMOVE_VAL = 3'd3;
  localparam logic [2:0] MODE_LOOKUP     = 3'd4;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_NO_DROP = 2'd2;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [4:0]         count;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
    logic               is_empty;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_SHIFT_DOWN,
    ACT_REMOVE_AT
  } cell_act_t;

  typedef struct packed {
    cell_act_t          act;
    logic signed [31:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } op_flags_t;

  typedef enum logic {
    ST_IDLE,
    ST_REPORT
  } state_t;

endpackage

/* hdl/sle_cell.sv */
// ----------------------------------------------------------------------------
// sle_cell
// one slot of the sorted row: compares against the broadcast value and takes
// it, its own, its left or its right neighbor's entry
// ----------------------------------------------------------------------------
module sle_cell (
  input  logic               clk,
  input  sle_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  logic               left_lt,
  input  logic signed [31:0] left_entry,
  input  logic signed [31:0] right_entry,
  output logic signed [31:0] entry,
  output logic               lt,
  output logic               hit
);

  logic signed [31:0] entry_r;
  logic signed [31:0] entry_nxt;

  assign entry = entry_r;
  assign lt    = occ && (entry_r < ctl.value);
  assign hit   = occ && left_lt && !lt && (entry_r == ctl.value);

  always_comb begin
    entry_nxt = entry_r;
    case (ctl.act)
      sle_pkg::ACT_INSERT: begin
        if (!lt) begin
          entry_nxt = left_lt ? ctl.value : left_entry;
        end
      end
      sle_pkg::ACT_SHIFT_DOWN: begin
        entry_nxt = right_entry;
      end
      sle_pkg::ACT_REMOVE_AT: begin
        if (!lt) begin
          entry_nxt = right_entry;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

/* hdl/sle_chain.sv */
// ----------------------------------------------------------------------------
// sle_chain
// row of cells with the fill count and the per-operation decision
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sle_chain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  sle_pkg::in_item_t         item,
  output logic [sle_pkg::CNT_W-1:0] count,
  output logic signed [31:0]        entries [sle_pkg::CAPACITY],
  output sle_pkg::op_flags_t        flags
);

  logic [sle_pkg::CNT_W-1:0] count_r;
  logic [sle_pkg::CNT_W-1:0] count_nxt;
  logic [sle_pkg::CAPACITY-1:0] lt_vec;
  logic [sle_pkg::CAPACITY-1:0] hit_vec;
  logic [sle_pkg::CAPACITY-1:0] occ_vec;
  sle_pkg::cell_ctl_t ctl;
  logic present;
  logic full;
  logic empty;

  assign present = |hit_vec;
  assign full    = (count_r == sle_pkg::CNT_W'(sle_pkg::CAPACITY));
  assign empty   = (count_r == '0);
  assign count   = count_r;

  genvar gi;
  generate
    for (gi = 0; gi < sle_pkg::CAPACITY; gi++) begin : g_cell
      logic               left_lt;
      logic signed [31:0] left_entry;
      logic signed [31:0] right_entry;

      assign occ_vec[gi] = (sle_pkg::CNT_W'(gi) < count_r);

      if (gi == 0) begin : g_first
        assign left_lt    = 1'b1;
        assign left_entry = entries[gi];
      end else begin : g_mid
        assign left_lt    = lt_vec[gi-1];
        assign left_entry = entries[gi-1];
      end

      if (gi == sle_pkg::CAPACITY - 1) begin : g_last
        assign right_entry = entries[gi];
      end else begin : g_inner
        assign right_entry = entries[gi+1];
      end

      sle_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occ         (occ_vec[gi]),
        .left_lt     (left_lt),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .entry       (entries[gi]),
        .lt          (lt_vec[gi]),
        .hit         (hit_vec[gi])
      );
    end
  endgenerate

  always_comb begin
    ctl.value    = item.value;
    ctl.act      = sle_pkg::ACT_HOLD;
    count_nxt    = count_r;
    flags.found  = present;
    flags.status = sle_pkg::STATUS_DONE;
    case (item.mode)
      sle_pkg::MODE_INSERT: begin
        if (full) begin
          flags.status = sle_pkg::STATUS_FULL;
        end else begin
          ctl.act   = sle_pkg::ACT_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      sle_pkg::MODE_POP_MIN: begin
        flags.found = 1'b0;
        if (empty) begin
          flags.status = sle_pkg::STATUS_NO_DROP;
        end else begin
          ctl.act   = sle_pkg::ACT_SHIFT_DOWN;
          count_nxt = count_r - 1'b1;
        end
      end
      sle_pkg::MODE_POP_MAX: begin
        flags.found = 1'b0;
        if (empty) begin
          flags.status = sle_pkg::STATUS_NO_DROP;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      sle_pkg::MODE_REMOVE_VAL: begin
        if (!present) begin
          flags.status = sle_pkg::STATUS_NO_DROP;
        end else begin
          ctl.act   = sle_pkg::ACT_REMOVE_AT;
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        flags.found = present;
      end
    endcase
    if (!accept) begin
      ctl.act   = sle_pkg::ACT_HOLD;
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  `SLE_ASSERT(a_count_bound, count_r <= sle_pkg::CNT_W'(sle_pkg::CAPACITY), "count above capacity")
  `SLE_ASSERT(a_row_sorted, ((lt_vec + 1'b1) & lt_vec) == '0, "row out of order")
  `SLE_ASSERT(a_single_hit, $onehot0(hit_vec), "more than one match position")

endmodule

/* hdl/sorted_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// sorted_list_engine_unit
// sorted store of signed 32-bit values used as a double-ended priority queue
// ----------------------------------------------------------------------------
// Each operation is a transfer, then a report: in the transfer cycle every
// cell of the sorted row compares its entry with the operand and the row
// shifts in one step; in the following cycle the output register loads the
// count and the end entries of the row. A new item is taken once that report
// is loaded and the output register is free or being emptied. No clearing
// pass follows reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_list_engine_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sle_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sle_pkg::out_item_t out_data
);

  sle_pkg::state_t state_r;
  sle_pkg::state_t state_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  sle_pkg::out_item_t out_data_r;
  sle_pkg::out_item_t out_data_nxt;
  sle_pkg::op_flags_t flags;
  sle_pkg::op_flags_t flags_r;
  logic [sle_pkg::CNT_W-1:0] count;
  logic [sle_pkg::IDX_W-1:0] last_pos;
  logic signed [31:0]        entries [sle_pkg::CAPACITY];
  logic                      accept;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == sle_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign last_pos  = sle_pkg::IDX_W'(count - 1'b1);

  sle_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_data),
    .count   (count),
    .entries (entries),
    .flags   (flags)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      sle_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = sle_pkg::ST_REPORT;
        end
      end
      sle_pkg::ST_REPORT: begin
        state_nxt             = sle_pkg::ST_IDLE;
        out_valid_nxt         = 1'b1;
        out_data_nxt.found    = flags_r.found;
        out_data_nxt.status   = flags_r.status;
        out_data_nxt.count    = count[4:0];
        out_data_nxt.is_empty = (count == '0);
        if (count == '0) begin
          out_data_nxt.smallest = '0;
          out_data_nxt.largest  = '0;
        end else begin
          out_data_nxt.smallest = entries[0];
          out_data_nxt.largest  = entries[last_pos];
        end
      end
      default: begin
        state_nxt = sle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sle_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      flags_r <= flags;
    end
  end

  `SLE_ASSERT(a_accept_clears_out, accept |=> !out_valid_r, "result pending over a transfer")
  `SLE_ASSERT(a_report_loads, state_r == sle_pkg::ST_REPORT |=> out_valid_r, "report not loaded")
  `SLE_ASSERT(a_full_count, out_valid_r && out_data_r.status == sle_pkg::STATUS_FULL |-> count == sle_pkg::CNT_W'(sle_pkg::CAPACITY), "full flag with free room")

endmodule
